FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the parity encoder.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cepe_pkg.sv
// Shared types, constants and GF(2^8) helpers for the Cauchy parity encoder.
// No dependencies; every other .sv file in this folder uses this package.
`timescale 1ns / 1ps

package cepe_pkg;

    localparam int ROWS = 4;
    localparam int ROW_W = 2;
    localparam int SYMBOL_BYTES = 2048;
    localparam int OFF_W = $clog2(SYMBOL_BYTES);
    localparam int LEN_W = OFF_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam logic [8:0] FIELD_POLY = 9'h11D;
    localparam logic [8:0] MAX_GROUP = 9'd254;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DATA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PARITY = 1'b1;

    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_CONFIG = 2'd2
    } status_t;

    typedef struct packed {
        logic                  command;
        logic [OFF_W-1:0]      offset;
        logic [7:0]            data;
        logic [ROW_W-1:0]      row;
        status_t               status;
        logic [ROWS-1:0]       row_mask;
        logic [ROWS-1:0][7:0]  coeff;
    } item_t;

    typedef logic [255:0][7:0] inv_table_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] a;
        logic [7:0] acc;
        begin
            a = {1'b0, x};
            acc = 8'd0;
            for (int n = 0; n < 8; n++)
            begin
                if (y[n])
                begin
                    acc = acc ^ a[7:0];
                end
                a = {a[7:0], 1'b0};
                if (a[8])
                begin
                    a = a ^ FIELD_POLY;
                end
            end
            return acc;
        end
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] x);
        logic [7:0] result;
        logic [7:0] base;
        logic [7:0] expo;
        begin
            result = 8'd1;
            base = x;
            expo = 8'd254;
            for (int n = 0; n < 8; n++)
            begin
                if (expo[n])
                begin
                    result = gf_mul(result, base);
                end
                base = gf_mul(base, base);
            end
            if (x == 8'd0)
            begin
                result = 8'd0;
            end
            return result;
        end
    endfunction

    function automatic inv_table_t build_inv_table();
        inv_table_t t;
        begin
            for (int i = 0; i < 256; i++)
            begin
                t[i] = gf_inv(8'(i));
            end
            return t;
        end
    endfunction

    localparam inv_table_t INV_TABLE = build_inv_table();

endpackage

FILE: rtl/cepe_front.sv
// Front end: configuration registers, input handshake and item classification.
// Depends on cepe_pkg for the item layout, status codes and inverse table.
`timescale 1ns / 1ps

module cepe_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       write_enable,
    input  logic [cepe_pkg::CFG_IDX_W-1:0] write_index,
    input  logic [7:0]                 write_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic [7:0]                 packet_index,
    input  logic [cepe_pkg::OFF_W-1:0] byte_offset,
    input  logic [7:0]                 data_byte,
    input  logic [cepe_pkg::ROW_W-1:0] parity_row,
    input  logic                       queue_full,
    input  logic                       clearing,
    output logic                       push,
    output cepe_pkg::item_t            item
);

    logic [7:0] num_data_reg;
    logic [2:0] num_parity_reg;
    logic [8:0] group_sum;
    logic       bad_config;
    logic       out_of_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_data_reg <= 8'd4;
            num_parity_reg <= 3'd2;
        end
        else if (write_enable)
        begin
            case (write_index)
                cepe_pkg::REG_NUM_DATA:
                begin
                    num_data_reg <= write_data;
                end
                cepe_pkg::REG_NUM_PARITY:
                begin
                    num_parity_reg <= write_data[2:0];
                end
                default:
                begin
                    num_data_reg <= num_data_reg;
                end
            endcase
        end
    end

    assign in_stall = queue_full || clearing;
    assign push = in_valid && !in_stall;

    assign group_sum = {1'b0, num_data_reg} + {6'd0, num_parity_reg};
    assign bad_config = (num_data_reg == 8'd0) || (num_parity_reg == 3'd0) ||
                        (num_parity_reg > 3'(cepe_pkg::ROWS)) ||
                        (group_sum > cepe_pkg::MAX_GROUP);

    always_comb
    begin
        item.command = command;
        item.offset = byte_offset;
        item.data = data_byte;
        item.row = parity_row;
        for (int j = 0; j < cepe_pkg::ROWS; j++)
        begin
            item.coeff[j] = cepe_pkg::INV_TABLE[packet_index ^ (num_data_reg + 8'(j))];
            if (command == cepe_pkg::CMD_READ)
            begin
                item.row_mask[j] = (parity_row == cepe_pkg::ROW_W'(j));
            end
            else
            begin
                item.row_mask[j] = (3'(j) < num_parity_reg);
            end
        end
        if (command == cepe_pkg::CMD_READ)
        begin
            out_of_range = ({1'b0, parity_row} >= num_parity_reg);
        end
        else
        begin
            out_of_range = (packet_index >= num_data_reg);
        end
        if (bad_config)
        begin
            item.status = cepe_pkg::STATUS_CONFIG;
        end
        else if (out_of_range)
        begin
            item.status = cepe_pkg::STATUS_RANGE;
        end
        else
        begin
            item.status = cepe_pkg::STATUS_OK;
        end
    end

endmodule

FILE: rtl/cepe_queue.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on cepe_pkg for the item layout.
`timescale 1ns / 1ps

module cepe_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cepe_pkg::item_t push_item,
    input  logic            pop,
    output cepe_pkg::item_t head,
    output logic            full,
    output logic            empty
);

    cepe_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/cepe_back.sv
// Back end: parity memory with its clearing pass, read-modify-write stage and
// output register. Depends on cepe_pkg for the item layout and GF multiply.
`timescale 1ns / 1ps

module cepe_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cepe_pkg::item_t            head,
    input  logic                       empty,
    output logic                       pop,
    output logic                       clearing,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 parity_byte,
    output logic [cepe_pkg::LEN_W-1:0] group_length,
    output logic [1:0]                 status
);

    logic [7:0] parity_mem [cepe_pkg::ROWS][cepe_pkg::SYMBOL_BYTES];

    logic [cepe_pkg::LEN_W-1:0]   clr_cnt_reg;
    logic                         s1_valid_reg;
    cepe_pkg::item_t              s1_item_reg;
    logic [cepe_pkg::ROWS-1:0][7:0] rdata_reg;
    logic                         fwd_valid_reg;
    logic [cepe_pkg::OFF_W-1:0]   fwd_offset_reg;
    logic [cepe_pkg::ROWS-1:0][7:0] fwd_data_reg;
    logic [cepe_pkg::LEN_W-1:0]   length_reg;
    logic [cepe_pkg::LEN_W-1:0]   length_next;
    logic                         out_valid_reg;
    logic [7:0]                   out_byte_reg;
    logic [cepe_pkg::LEN_W-1:0]   out_length_reg;
    cepe_pkg::status_t            out_status_reg;

    logic                         advance;
    logic                         write_en;
    logic [cepe_pkg::OFF_W-1:0]   rd_addr;
    logic [cepe_pkg::LEN_W-1:0]   end_offset;
    logic [cepe_pkg::ROWS-1:0][7:0] old_row;
    logic [cepe_pkg::ROWS-1:0][7:0] new_row;
    logic [7:0]                   result_byte;

    assign clearing = !clr_cnt_reg[cepe_pkg::OFF_W];
    assign advance = !out_valid_reg || !out_stall;
    assign pop = advance && !empty && !clearing;
    assign write_en = s1_valid_reg && advance && (s1_item_reg.status == cepe_pkg::STATUS_OK);
    assign rd_addr = advance ? head.offset : s1_item_reg.offset;
    assign end_offset = {1'b0, s1_item_reg.offset} + cepe_pkg::LEN_W'(1);

    always_comb
    begin
        for (int r = 0; r < cepe_pkg::ROWS; r++)
        begin
            if (fwd_valid_reg && (fwd_offset_reg == s1_item_reg.offset))
            begin
                old_row[r] = fwd_data_reg[r];
            end
            else
            begin
                old_row[r] = rdata_reg[r];
            end
            if (!s1_item_reg.row_mask[r])
            begin
                new_row[r] = old_row[r];
            end
            else if (s1_item_reg.command == cepe_pkg::CMD_READ)
            begin
                new_row[r] = 8'd0;
            end
            else
            begin
                new_row[r] = old_row[r] ^
                             cepe_pkg::gf_mul(s1_item_reg.coeff[r], s1_item_reg.data);
            end
        end
        if (s1_item_reg.command == cepe_pkg::CMD_READ &&
            s1_item_reg.status == cepe_pkg::STATUS_OK)
        begin
            result_byte = old_row[s1_item_reg.row];
        end
        else
        begin
            result_byte = 8'd0;
        end
        length_next = length_reg;
        if (write_en && s1_item_reg.command == cepe_pkg::CMD_ACCUMULATE &&
            end_offset > length_reg)
        begin
            length_next = end_offset;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < cepe_pkg::ROWS; r++)
        begin
            if (clearing)
            begin
                parity_mem[r][clr_cnt_reg[cepe_pkg::OFF_W-1:0]] <= 8'd0;
            end
            else if (write_en)
            begin
                parity_mem[r][s1_item_reg.offset] <= new_row[r];
            end
            rdata_reg[r] <= parity_mem[r][rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            length_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + cepe_pkg::LEN_W'(1);
            end
            if (advance)
            begin
                s1_valid_reg <= pop;
                out_valid_reg <= s1_valid_reg;
            end
            if (write_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            length_reg <= length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg <= head;
        end
        if (write_en)
        begin
            fwd_offset_reg <= s1_item_reg.offset;
            fwd_data_reg <= new_row;
        end
        if (advance && s1_valid_reg)
        begin
            out_byte_reg <= result_byte;
            out_length_reg <= length_next;
            out_status_reg <= s1_item_reg.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign parity_byte = out_byte_reg;
    assign group_length = out_length_reg;
    assign status = out_status_reg;

endmodule

FILE: rtl/cauchy_erasure_parity_encoder_core.sv
// Cauchy Reed-Solomon erasure parity encoder over GF(2^8), top level.
// Depends on cepe_pkg, cepe_front, cepe_queue, cepe_back and assert_macros.svh.
// After reset the block clears its 4 x 2048 byte parity memory, one offset of all
// rows per cycle, and accepts no transaction until that pass ends; configuration
// writes are taken throughout. After that it accepts one transaction per cycle
// while the output is not stalled. Each result goes through the queue, the memory
// read and the read-modify-write of every parity row at that offset, with the last
// written offset forwarded so that back-to-back updates to one offset are exact.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cauchy_erasure_parity_encoder_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           write_enable,
    input  logic [cepe_pkg::CFG_IDX_W-1:0] write_index,
    input  logic [7:0]                     write_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [7:0]                     packet_index,
    input  logic [10:0]                    byte_offset,
    input  logic [7:0]                     data_byte,
    input  logic [1:0]                     parity_row,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     parity_byte,
    output logic [11:0]                    group_length,
    output logic [1:0]                     status
);

    cepe_pkg::item_t front_item;
    cepe_pkg::item_t head_item;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    logic clearing;

    cepe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .packet_index (packet_index),
        .byte_offset  (byte_offset),
        .data_byte    (data_byte),
        .parity_row   (parity_row),
        .queue_full   (queue_full),
        .clearing     (clearing),
        .push         (push),
        .item         (front_item)
    );

    cepe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    cepe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_item),
        .empty        (queue_empty),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parity_byte  (parity_byte),
        .group_length (group_length),
        .status       (status)
    );

    `ASSERT_HOLDS(a_no_accept_while_clearing, !(push && clearing), "transaction accepted during clearing pass")
    `ASSERT_HOLDS(a_no_pop_when_empty, !(pop && queue_empty), "queue popped while empty")
    `ASSERT_HOLDS(a_flagged_byte_zero, !(out_valid && status != cepe_pkg::STATUS_OK && parity_byte != 8'd0), "flagged result carries a nonzero byte")
    `ASSERT_NEXT(a_length_monotonic, out_valid, group_length >= $past(group_length), "group length decreased")

endmodule

FILE: test/cauchy_erasure_parity_encoder_core_test.sv
// Self-checking testbench for the Cauchy Reed-Solomon erasure parity encoder core.
// Depends on cepe_pkg and cauchy_erasure_parity_encoder_core; predicts each result in GF(2^8).
// Directed, configuration, random and backpressure tests run in turn from one initial block.
`timescale 1ns / 1ps

module cauchy_erasure_parity_encoder_core_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RING_DEPTH = 64;

    typedef struct {
        logic [7:0]  parity;
        logic [11:0] length;
        cepe_pkg::status_t code;
    } parity_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        write_enable = 1'b0;
    logic [cepe_pkg::CFG_IDX_W-1:0] write_index = cepe_pkg::REG_NUM_DATA;
    logic [7:0]  write_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = cepe_pkg::CMD_ACCUMULATE;
    logic [7:0]  packet_index = 8'd0;
    logic [10:0] byte_offset = 11'd0;
    logic [7:0]  data_byte = 8'd0;
    logic [1:0]  parity_row = 2'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  parity_byte;
    logic [11:0] group_length;
    logic [1:0]  status;

    logic [7:0]  parity_mem [cepe_pkg::ROWS][cepe_pkg::SYMBOL_BYTES];
    logic [7:0]  inverse_of [256];
    logic [11:0] longest_seen;
    int          k_data;
    int          m_parity;
    parity_result_t result_ring [RING_DEPTH];
    int          ring_wr = 0;
    int          ring_rd = 0;
    int          errors = 0;
    int          cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;

    cauchy_erasure_parity_encoder_core u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .write_enable(write_enable),
        .write_index(write_index),
        .write_data(write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .packet_index(packet_index),
        .byte_offset(byte_offset),
        .data_byte(data_byte),
        .parity_row(parity_row),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .parity_byte(parity_byte),
        .group_length(group_length),
        .status(status)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] sh;
        begin
            acc = 8'd0;
            sh = x;
            for (int n = 0; n < 8; n++)
            begin
                if (y[n])
                begin
                    acc ^= sh;
                end
                sh = sh[7] ? ({sh[6:0], 1'b0} ^ 8'h1D) : {sh[6:0], 1'b0};
            end
            return acc;
        end
    endfunction

    function automatic logic config_broken();
        return k_data == 0 || m_parity == 0 || m_parity > cepe_pkg::ROWS ||
               k_data + m_parity > 254;
    endfunction

    function automatic parity_result_t predict_parity(input logic cmd, input logic [7:0] pidx,
        input logic [10:0] off, input logic [7:0] db, input logic [1:0] row);
        parity_result_t r;
        logic [7:0] denom;
        begin
            r.parity = 8'd0;
            r.code = cepe_pkg::STATUS_OK;
            if (config_broken())
            begin
                r.code = cepe_pkg::STATUS_CONFIG;
            end
            else if (cmd == cepe_pkg::CMD_ACCUMULATE)
            begin
                if (pidx >= k_data)
                begin
                    r.code = cepe_pkg::STATUS_RANGE;
                end
                else
                begin
                    for (int j = 0; j < m_parity; j++)
                    begin
                        denom = pidx ^ 8'(k_data + j);
                        parity_mem[j][off] ^= field_product(inverse_of[denom], db);
                    end
                    if (off + 12'd1 > longest_seen)
                    begin
                        longest_seen = off + 12'd1;
                    end
                end
            end
            else if (row >= m_parity)
            begin
                r.code = cepe_pkg::STATUS_RANGE;
            end
            else
            begin
                r.parity = parity_mem[row][off];
                parity_mem[row][off] = 8'd0;
            end
            r.length = longest_seen;
            return r;
        end
    endfunction

    task automatic report(input string what, input int got, input int want);
        begin
            $display("mismatch in %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        parity_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (ring_wr == ring_rd)
            begin
                report("unexpected transaction", parity_byte, -1);
            end
            else
            begin
                want = result_ring[ring_rd % RING_DEPTH];
                ring_rd++;
                if (parity_byte !== want.parity)
                begin
                    report("parity_byte", parity_byte, want.parity);
                end
                if (group_length !== want.length)
                begin
                    report("group_length", group_length, want.length);
                end
                if (status !== want.code)
                begin
                    report("status", status, want.code);
                end
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] pidx, input logic [10:0] off,
        input logic [7:0] db, input logic [1:0] row);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            command <= cmd;
            packet_index <= pidx;
            byte_offset <= off;
            data_byte <= db;
            parity_row <= row;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            result_ring[ring_wr % RING_DEPTH] = predict_parity(cmd, pidx, off, db, row);
            ring_wr++;
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (ring_wr != ring_rd)
            begin
                @(posedge clk);
            end
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [cepe_pkg::CFG_IDX_W-1:0] idx,
        input logic [7:0] value);
        begin
            write_enable <= 1'b1;
            write_index <= idx;
            write_data <= value;
            @(posedge clk);
            if (idx == cepe_pkg::REG_NUM_DATA)
            begin
                k_data = value;
            end
            else
            begin
                m_parity = value & 8'h07;
            end
        end
    endtask

    task automatic set_group(input logic [7:0] k, input logic [7:0] m);
        begin
            drain();
            write_register(cepe_pkg::REG_NUM_DATA, k);
            write_register(cepe_pkg::REG_NUM_PARITY, m);
            write_enable <= 1'b0;
        end
    endtask

    task automatic send_random(input int count);
        int r;
        logic [10:0] off;
        begin
            for (int n = 0; n < count; n++)
            begin
                r = $urandom_range(99);
                off = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(15));
                if (r < 55 && !config_broken())
                begin
                    send_item(cepe_pkg::CMD_ACCUMULATE, 8'($urandom_range(k_data - 1)), off,
                        8'($urandom), 2'($urandom));
                end
                else if (r < 85 && !config_broken())
                begin
                    send_item(cepe_pkg::CMD_READ, 8'($urandom), off, 8'($urandom),
                        2'($urandom_range(m_parity - 1)));
                end
                else
                begin
                    send_item(1'($urandom), 8'($urandom), 11'($urandom), 8'($urandom),
                        2'($urandom));
                end
            end
        end
    endtask

    task automatic test_directed();
        begin
            send_item(cepe_pkg::CMD_ACCUMULATE, 8'd0, 11'd0, 8'hFF, 2'd0);
            send_item(cepe_pkg::CMD_ACCUMULATE, 8'd3, 11'd0, 8'h01, 2'd3);
            send_item(cepe_pkg::CMD_ACCUMULATE, 8'd3, 11'd2047, 8'h00, 2'd0);
            send_item(cepe_pkg::CMD_ACCUMULATE, 8'd1, 11'd2047, 8'hA5, 2'd0);
            send_item(cepe_pkg::CMD_ACCUMULATE, 8'd4, 11'd5, 8'h5A, 2'd0);
            send_item(cepe_pkg::CMD_ACCUMULATE, 8'd255, 11'd5, 8'h5A, 2'd0);
            send_item(cepe_pkg::CMD_READ, 8'd0, 11'd0, 8'd0, 2'd0);
            send_item(cepe_pkg::CMD_READ, 8'd0, 11'd0, 8'd0, 2'd0);
            send_item(cepe_pkg::CMD_READ, 8'd0, 11'd0, 8'd0, 2'd1);
            send_item(cepe_pkg::CMD_READ, 8'd0, 11'd2047, 8'd0, 2'd1);
            send_item(cepe_pkg::CMD_READ, 8'd0, 11'd2047, 8'd0, 2'd0);
            send_item(cepe_pkg::CMD_READ, 8'd0, 11'd2047, 8'd0, 2'd2);
            send_item(cepe_pkg::CMD_READ, 8'd0, 11'd9, 8'd0, 2'd3);
            send_item(cepe_pkg::CMD_ACCUMULATE, 8'd2, 11'd7, 8'h80, 2'd0);
            send_item(cepe_pkg::CMD_ACCUMULATE, 8'd2, 11'd7, 8'h80, 2'd0);
            send_item(cepe_pkg::CMD_READ, 8'd0, 11'd7, 8'd0, 2'd1);
        end
    endtask

    task automatic test_group_extremes();
        begin
            set_group(8'd1, 8'd1);
            send_random(30);
            set_group(8'd253, 8'd1);
            send_random(30);
            set_group(8'd250, 8'd4);
            send_random(40);
            set_group(8'd200, 8'd3);
            send_random(30);
        end
    endtask

    task automatic test_bad_config();
        begin
            set_group(8'd0, 8'd2);
            send_random(6);
            set_group(8'd4, 8'd0);
            send_random(6);
            set_group(8'd4, 8'd5);
            send_random(6);
            set_group(8'd4, 8'd7);
            send_random(6);
            set_group(8'd252, 8'd3);
            send_random(6);
            set_group(8'd255, 8'd4);
            send_random(6);
        end
    endtask

    task automatic test_idle_phases();
        begin
            set_group(8'd10, 8'd4);
            idle_pct = 68;
            stall_pct = 0;
            send_random(80);
            idle_pct = 0;
            stall_pct = 68;
            send_random(80);
            idle_pct = 8;
            stall_pct = 8;
            send_random(80);
            idle_pct = 0;
            stall_pct = 0;
            set_group(8'd6, 8'd2);
            send_random(60);
        end
    endtask

    task automatic test_backpressure();
        begin
            drain();
            hold_left = 80;
            send_random(40);
            idle_pct = 68;
            stall_pct = 68;
            send_random(40);
        end
    endtask

    initial
    begin
        for (int x = 0; x < 256; x++)
        begin
            inverse_of[x] = 8'd0;
            for (int y = 1; y < 256; y++)
            begin
                if (field_product(8'(x), 8'(y)) == 8'd1)
                begin
                    inverse_of[x] = 8'(y);
                end
            end
        end
        for (int j = 0; j < cepe_pkg::ROWS; j++)
        begin
            for (int b = 0; b < cepe_pkg::SYMBOL_BYTES; b++)
            begin
                parity_mem[j][b] = 8'd0;
            end
        end
        longest_seen = 12'd0;
        k_data = 4;
        m_parity = 2;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_group_extremes();
        test_bad_config();
        test_idle_phases();
        test_backpressure();
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && ring_wr == ring_rd)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/cepe_pkg.sv
rtl/cepe_front.sv
rtl/cepe_queue.sv
rtl/cepe_back.sv
rtl/cauchy_erasure_parity_encoder_core.sv
test/cauchy_erasure_parity_encoder_core_test.sv
